// File: design/pls_pkg.sv
// Shared types and constants for the positional list store.
`timescale 1ns / 1ps

package pls_pkg;

	localparam int PLS_CAPACITY   = 16;
	localparam int PLS_DATA_WIDTH = 32;

	localparam int OP_W     = 3;
	localparam int POS_W    = 5;
	localparam int VALUE_W  = 32;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 5;
	localparam int IN_TDATA_W  = 40;
	localparam int OUT_TDATA_W = 40;

	typedef enum logic [OP_W-1:0] {
		OP_ADD_FRONT  = 3'd0,
		OP_ADD_REAR   = 3'd1,
		OP_REM_FRONT  = 3'd2,
		OP_REM_REAR   = 3'd3,
		OP_INSERT_POS = 3'd4,
		OP_REMOVE_POS = 3'd5
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 2'd0,
		ST_UNDERFLOW = 2'd1,
		ST_RANGE     = 2'd2,
		ST_FULL      = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		SLOT_FRONT,
		SLOT_REAR,
		SLOT_POS
	} slot_t;

	typedef enum logic {
		S_EMPTY,
		S_HELD
	} state_t;

	// Controller to datapath.
	typedef struct packed {
		logic    load;
		logic    do_ins;
		logic    do_rem;
		slot_t   slot;
		status_t status;
	} cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic empty;
		logic full;
		logic ins_pos_ok;
		logic rem_pos_ok;
	} sts_t;

endpackage

// File: design/positional_list_store_top.sv
// Top level of the positional list store.
`timescale 1ns / 1ps
//
// Bounded ordered list of signed values, one list operation per item.
// Input channel s_*: each item carries op, position and value; op selects
// add front/rear, remove front/rear, insert before a one-based position,
// or remove at a one-based position.
// Output channel m_*: exactly one result item per input item, carrying the
// removed value (zero unless a remove succeeded), a status code (ok,
// underflow, position out of range, list full) and the count afterwards.
// The result is registered and appears in the cycle after acceptance.
// Throughput: one item per cycle while results are taken; every entry cell
// shifts or holds in parallel in the accepting cycle, so nothing iterates.
// A single result register parts the two sides: s_tready stays high while
// that register is empty or is being drained in the same cycle. When the
// receiver stalls, the result holds and s_tready drops until it is taken.
// Reset clears the fill count and the result-register flag; the list is
// empty afterwards and the entry cells are never read before written.
// A failed operation leaves the list untouched.

module positional_list_store_top
	import pls_pkg::*;
#(
	parameter int CAPACITY   = PLS_CAPACITY,
	parameter int DATA_WIDTH = PLS_DATA_WIDTH
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,  // op[2:0], position[7:3], value[39:8]
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata   // removed_value[31:0], status[33:32],
	                                         // count[38:34], zero[39]
);

	cmd_t                cmd;
	sts_t                sts;
	logic [OP_W-1:0]     op;
	logic [POS_W-1:0]    position;
	logic [VALUE_W-1:0]  value;
	logic [VALUE_W-1:0]  removed_value;
	logic [STATUS_W-1:0] status;
	logic [COUNT_W-1:0]  count;

	// Unpack the input item.
	assign op       = s_tdata[2:0];
	assign position = s_tdata[7:3];
	assign value    = s_tdata[39:8];

	pls_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.op       (op),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	pls_dp #(
		.CAPACITY   (CAPACITY),
		.DATA_WIDTH (DATA_WIDTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.position      (position),
		.value         (value),
		.cmd           (cmd),
		.sts           (sts),
		.removed_value (removed_value),
		.status        (status),
		.count         (count)
	);

	// Pack the result item; pad the top bit to a whole byte.
	assign m_tdata = {1'b0, count, status, removed_value};

endmodule

// File: design/pls_ctrl.sv
// Controller: handshake, result-register occupancy and operation decode.
`timescale 1ns / 1ps

module pls_ctrl
	import pls_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	output logic            s_tready,
	input  logic [OP_W-1:0] op,
	output logic            m_tvalid,
	input  logic            m_tready,
	input  sts_t            sts,
	output cmd_t            cmd
);

	state_t state_q;
	state_t state_d;
	logic   accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_EMPTY;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		s_tready = (state_q == S_EMPTY) || m_tready;
		m_tvalid = (state_q == S_HELD);
		accept   = s_tvalid && s_tready;

		state_d = state_q;
		if (accept) begin
			state_d = S_HELD;
		end else if (m_tready) begin
			state_d = S_EMPTY;
		end

		cmd.load   = accept;
		cmd.do_ins = 1'b0;
		cmd.do_rem = 1'b0;
		cmd.slot   = SLOT_FRONT;
		cmd.status = ST_OK;
		unique case (op)
			OP_ADD_FRONT, OP_ADD_REAR: begin
				cmd.slot = (op == OP_ADD_FRONT) ? SLOT_FRONT : SLOT_REAR;
				if (sts.full) begin
					cmd.status = ST_FULL;
				end else begin
					cmd.do_ins = accept;
				end
			end
			OP_REM_FRONT, OP_REM_REAR: begin
				cmd.slot = (op == OP_REM_FRONT) ? SLOT_FRONT : SLOT_REAR;
				if (sts.empty) begin
					cmd.status = ST_UNDERFLOW;
				end else begin
					cmd.do_rem = accept;
				end
			end
			OP_INSERT_POS: begin
				cmd.slot = SLOT_POS;
				if (!sts.ins_pos_ok) begin
					cmd.status = ST_RANGE;
				end else if (sts.full) begin
					cmd.status = ST_FULL;
				end else begin
					cmd.do_ins = accept;
				end
			end
			OP_REMOVE_POS: begin
				cmd.slot = SLOT_POS;
				if (!sts.rem_pos_ok) begin
					cmd.status = ST_RANGE;
				end else begin
					cmd.do_rem = accept;
				end
			end
			default: begin
				// unused codes: ok, no change
			end
		endcase
	end

	ap_ins_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.do_ins |-> !sts.full)
		else $error("insert issued on a full list");
	ap_rem_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.do_rem |-> !sts.empty)
		else $error("remove issued on an empty list");
	ap_result_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> m_tvalid)
		else $error("accepted item produced no result");

endmodule

// File: design/pls_dp.sv
// Datapath: shifting entry cells, fill count and result register.
`timescale 1ns / 1ps

module pls_dp
	import pls_pkg::*;
#(
	parameter int CAPACITY   = PLS_CAPACITY,
	parameter int DATA_WIDTH = PLS_DATA_WIDTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [POS_W-1:0]    position,
	input  logic [VALUE_W-1:0]  value,
	input  cmd_t                cmd,
	output sts_t                sts,
	output logic [VALUE_W-1:0]  removed_value,
	output logic [STATUS_W-1:0] status,
	output logic [COUNT_W-1:0]  count
);

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

	logic [DATA_WIDTH-1:0] cell_q [CAPACITY];
	logic [CNT_W-1:0]      fill_q;
	logic [CNT_W-1:0]      fill_d;
	logic [IDX_W-1:0]      slot_idx;
	logic [POS_W-1:0]      pos_m1;
	logic [CMP_W-1:0]      pos_ext;
	logic [CMP_W-1:0]      fill_ext;
	logic [63:0]           value_ext;
	logic [DATA_WIDTH-1:0] cell_in;
	logic [DATA_WIDTH-1:0] cell_out;
	logic [63:0]           out_ext;

	logic [VALUE_W-1:0]  removed_q;
	logic [STATUS_W-1:0] status_q;
	logic [COUNT_W-1:0]  count_q;

	always_comb begin
		pos_ext  = CMP_W'(position);
		fill_ext = CMP_W'(fill_q);
		pos_m1   = position - POS_W'(1);

		sts.empty      = (fill_q == '0);
		sts.full       = (fill_q == CNT_W'(CAPACITY));
		sts.ins_pos_ok = (position != '0) && (pos_ext <= fill_ext + CMP_W'(1));
		sts.rem_pos_ok = (position != '0) && (pos_ext <= fill_ext);

		unique case (cmd.slot)
			SLOT_FRONT: slot_idx = '0;
			SLOT_REAR:  slot_idx = cmd.do_rem ? IDX_W'(fill_q - CNT_W'(1)) : IDX_W'(fill_q);
			SLOT_POS:   slot_idx = IDX_W'(pos_m1);
			default:    slot_idx = '0;
		endcase

		value_ext = {32'b0, value};
		cell_in   = value_ext[DATA_WIDTH-1:0];
		cell_out  = cell_q[slot_idx];
		out_ext   = 64'($signed(cell_out));

		fill_d = fill_q;
		if (cmd.do_ins) begin
			fill_d = fill_q + CNT_W'(1);
		end else if (cmd.do_rem) begin
			fill_d = fill_q - CNT_W'(1);
		end
	end

	// Each cell shifts toward the rear, toward the front, or holds.
	always_ff @(posedge clk) begin
		for (int i = 0; i < CAPACITY; i++) begin
			if (cmd.do_ins) begin
				if (IDX_W'(i) == slot_idx) begin
					cell_q[i] <= cell_in;
				end else if (IDX_W'(i) > slot_idx) begin
					cell_q[i] <= cell_q[(i == 0) ? 0 : i - 1];
				end
			end else if (cmd.do_rem) begin
				if (IDX_W'(i) >= slot_idx && i < CAPACITY - 1) begin
					cell_q[i] <= cell_q[(i == CAPACITY - 1) ? i : i + 1];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else begin
			fill_q <= fill_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			removed_q <= cmd.do_rem ? out_ext[VALUE_W-1:0] : '0;
			status_q  <= cmd.status;
			count_q   <= COUNT_W'(fill_d);
		end
	end

	assign removed_value = removed_q;
	assign status        = status_q;
	assign count         = count_q;

	ap_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_W'(CAPACITY))
		else $error("fill count beyond capacity");
	ap_ins_grows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.do_ins |=> fill_q == $past(fill_q) + CNT_W'(1))
		else $error("insert did not grow the list");
	ap_rem_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.do_rem |=> fill_q == $past(fill_q) - CNT_W'(1))
		else $error("remove did not shrink the list");

endmodule

// File: sim/positional_list_store_top_tb.sv
// Self-checking stream testbench for the positional list store.
`timescale 1ns / 1ps

module positional_list_store_top_tb;
	import pls_pkg::*;

	// Op codes the block ignores; they must still return one result.
	localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
	localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

	localparam int RANDOM_ITEMS = 700;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int REPORT_MAX   = 10;

	typedef struct packed {
		logic [VALUE_W-1:0] removed;
		status_t            status;
		logic [COUNT_W-1:0] count;
	} list_result_t;

	// One row of the directed plan; the typed result is used only when known is set.
	typedef struct packed {
		logic [OP_W-1:0]    op;
		logic [POS_W-1:0]   pos;
		logic [VALUE_W-1:0] val;
		logic [7:0]         reps;
		logic               known;
		list_result_t       typed;
	} plan_row_t;

	logic                   clk;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata;   // op[2:0], position[7:3], value[39:8]
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;   // removed_value[31:0], status[33:32],
	                                   // count[38:34], zero[39]

	// Shadow copy of the list, index 0 is the front.
	logic signed [PLS_DATA_WIDTH-1:0] held[$];
	list_result_t pending[$];
	plan_row_t    plan[$];

	int  errors;
	int  items_sent;
	int  directed_items;
	int  results_seen;
	int  cycles;
	int  max_fill;
	int  status_hits[4];
	bit  steady;

	positional_list_store_top DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	// Apply one list operation to the shadow list and return what the block should report.
	function automatic list_result_t apply_list_op(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
			logic [VALUE_W-1:0] val);
		list_result_t r;
		int fill;
		int k;
		r.removed = '0;
		r.status  = ST_OK;
		fill      = held.size();
		k         = int'(pos) - 1;
		case (op)
			OP_ADD_FRONT, OP_ADD_REAR: begin
				if (fill >= PLS_CAPACITY)
					r.status = ST_FULL;
				else if (op == OP_ADD_FRONT)
					held.push_front(val[PLS_DATA_WIDTH-1:0]);
				else
					held.push_back(val[PLS_DATA_WIDTH-1:0]);
			end
			OP_REM_FRONT, OP_REM_REAR: begin
				if (fill == 0)
					r.status = ST_UNDERFLOW;
				else if (op == OP_REM_FRONT)
					r.removed = held.pop_front();
				else
					r.removed = held.pop_back();
			end
			OP_INSERT_POS: begin
				// position fill+1 appends; a legal slot on a full list reports full
				if (pos < 1 || int'(pos) > fill + 1)
					r.status = ST_RANGE;
				else if (fill >= PLS_CAPACITY)
					r.status = ST_FULL;
				else
					held.insert(k, val[PLS_DATA_WIDTH-1:0]);
			end
			OP_REMOVE_POS: begin
				if (pos < 1 || int'(pos) > fill)
					r.status = ST_RANGE;
				else begin
					r.removed = held[k];
					held.delete(k);
				end
			end
			default: ;
		endcase
		r.count = COUNT_W'(held.size());
		if (held.size() > max_fill)
			max_fill = held.size();
		status_hits[r.status]++;
		return r;
	endfunction

	function automatic int gap_draw();
		return steady ? 0 : $urandom_range(0, 10);
	endfunction

	function automatic plan_row_t row(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
			logic [VALUE_W-1:0] val, int reps, bit known, logic [VALUE_W-1:0] rv,
			status_t st, int cnt);
		plan_row_t p;
		p.op            = op;
		p.pos           = pos;
		p.val           = val;
		p.reps          = 8'(reps);
		p.known         = known;
		p.typed.removed = rv;
		p.typed.status  = st;
		p.typed.count   = COUNT_W'(cnt);
		return p;
	endfunction

	task automatic log_failure(string msg);
		errors++;
		if (errors <= REPORT_MAX)
			$display("[%0t] MISMATCH %s", $time, msg);
	endtask

	// Offer one item after a random gap, hold it until taken, then record its expected result.
	// Enter and leave at a falling edge.
	task automatic send_item(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
			logic [VALUE_W-1:0] val, bit known, list_result_t typed);
		int n;
		list_result_t want;
		n = gap_draw();
		if (n > 0) begin
			s_tvalid <= 1'b0;
			repeat (n) @(negedge clk);
		end
		s_tdata  <= {val, pos, op};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		want = apply_list_op(op, pos, val);
		pending.push_back(known ? typed : want);
		items_sent++;
		@(negedge clk);
	endtask

	// Check every result taken by the receiver against the oldest expectation.
	always @(posedge clk) begin : check_results
		list_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			results_seen++;
			if (pending.size() == 0)
				log_failure($sformatf("result with nothing expected: tdata=%h", m_tdata));
			else begin
				want = pending.pop_front();
				if (m_tdata[VALUE_W-1:0] !== want.removed
						|| m_tdata[VALUE_W+STATUS_W-1:VALUE_W] !== want.status
						|| m_tdata[VALUE_W+STATUS_W+COUNT_W-1:VALUE_W+STATUS_W] !== want.count
						|| m_tdata[OUT_TDATA_W-1] !== 1'b0)
					log_failure($sformatf(
						"result %0d: exp removed=%h status=%0d count=%0d, got tdata=%h",
						results_seen, want.removed, want.status, want.count, m_tdata));
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results still expected",
				cycles, pending.size());
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Receiver: stall a random number of cycles before each result.
	initial begin : drain_results
		int n;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			n = gap_draw();
			@(negedge clk);
			if (n > 0) begin
				m_tready <= 1'b0;
				repeat (n) @(negedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!(m_tvalid && m_tready));
		end
	end

	initial begin : run_stimulus
		list_result_t none;
		logic [OP_W-1:0]    op;
		logic [POS_W-1:0]   pos;
		logic [VALUE_W-1:0] val;
		int r;
		int k;
		bit grow;
		bit add;

		none     = '0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		arst_n   = 1'b0;
		steady   = 1'b0;

		// Empty-list errors, position bounds, extremes, spare ops, fill to full and drain.
		plan.push_back(row(OP_REM_FRONT,  5'd0,  32'h0,        1, 1, 32'h0, ST_UNDERFLOW, 0));
		plan.push_back(row(OP_REM_REAR,   5'd31, 32'h0,        1, 1, 32'h0, ST_UNDERFLOW, 0));
		plan.push_back(row(OP_REMOVE_POS, 5'd1,  32'h0,        1, 1, 32'h0, ST_RANGE,     0));
		plan.push_back(row(OP_INSERT_POS, 5'd0,  32'h1,        1, 1, 32'h0, ST_RANGE,     0));
		plan.push_back(row(OP_INSERT_POS, 5'd2,  32'h1,        1, 1, 32'h0, ST_RANGE,     0));
		plan.push_back(row(OP_INSERT_POS, 5'd1,  32'h7FFFFFFF, 1, 1, 32'h0, ST_OK,        1));
		plan.push_back(row(OP_ADD_FRONT,  5'd0,  32'h80000000, 1, 1, 32'h0, ST_OK,        2));
		plan.push_back(row(OP_ADD_REAR,   5'd0,  32'hFFFFFFFF, 1, 1, 32'h0, ST_OK,        3));
		plan.push_back(row(OP_SPARE_LO,   5'd1,  32'h12345678, 1, 1, 32'h0, ST_OK,        3));
		plan.push_back(row(OP_SPARE_HI,   5'd31, 32'hFFFFFFFF, 1, 1, 32'h0, ST_OK,        3));
		plan.push_back(row(OP_REMOVE_POS, 5'd1,  32'h0, 1, 1, 32'h80000000, ST_OK,        2));
		plan.push_back(row(OP_INSERT_POS, 5'd3,  32'h12345678, 1, 0, 32'h0, ST_OK,        0));
		plan.push_back(row(OP_REMOVE_POS, 5'd3,  32'h0,        1, 0, 32'h0, ST_OK,        0));
		plan.push_back(row(OP_ADD_REAR,   5'd0,  32'h55AA55AA, 14, 0, 32'h0, ST_OK,       0));
		plan.push_back(row(OP_ADD_FRONT,  5'd0,  32'h1,        1, 1, 32'h0, ST_FULL,     16));
		plan.push_back(row(OP_ADD_REAR,   5'd0,  32'h1,        1, 1, 32'h0, ST_FULL,     16));
		plan.push_back(row(OP_INSERT_POS, 5'd17, 32'h1,        1, 1, 32'h0, ST_FULL,     16));
		plan.push_back(row(OP_INSERT_POS, 5'd18, 32'h1,        1, 1, 32'h0, ST_RANGE,    16));
		plan.push_back(row(OP_INSERT_POS, 5'd31, 32'h1,        1, 1, 32'h0, ST_RANGE,    16));
		plan.push_back(row(OP_REMOVE_POS, 5'd17, 32'h0,        1, 1, 32'h0, ST_RANGE,    16));
		plan.push_back(row(OP_REMOVE_POS, 5'd16, 32'h0,        1, 0, 32'h0, ST_OK,        0));
		plan.push_back(row(OP_REMOVE_POS, 5'd0,  32'h0,        1, 1, 32'h0, ST_RANGE,    15));
		plan.push_back(row(OP_REM_REAR,   5'd0,  32'h0,        1, 0, 32'h0, ST_OK,        0));
		plan.push_back(row(OP_REM_FRONT,  5'd0,  32'h0,       14, 0, 32'h0, ST_OK,        0));
		plan.push_back(row(OP_REM_REAR,   5'd0,  32'h0,        1, 1, 32'h0, ST_UNDERFLOW, 0));

		// Hold reset, then release it at a falling edge.
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (plan[i])
			repeat (plan[i].reps)
				send_item(plan[i].op, plan[i].pos, plan[i].val, plan[i].known, plan[i].typed);
		directed_items = items_sent;

		// Alternate growing and shrinking phases so the list swings between empty and full.
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			steady = (i >= 250 && i < 330) || (i >= 550 && i < 630);
			grow   = ((i / 60) % 2) == 0;
			r      = $urandom_range(0, 99);
			k      = $urandom_range(0, 2);
			if (r < 4)
				op = (r < 2) ? OP_SPARE_LO : OP_SPARE_HI;
			else begin
				add = $urandom_range(0, 99) < (grow ? 70 : 30);
				if (add)
					op = (k == 0) ? OP_ADD_FRONT : (k == 1) ? OP_ADD_REAR : OP_INSERT_POS;
				else
					op = (k == 0) ? OP_REM_FRONT : (k == 1) ? OP_REM_REAR : OP_REMOVE_POS;
			end
			// Keep most positions near the live range, the rest anywhere in the field.
			if ($urandom_range(0, 99) < 80)
				pos = POS_W'($urandom_range(0, held.size() + 1));
			else
				pos = POS_W'($urandom_range(0, 31));
			case ($urandom_range(0, 9))
				0:       val = 32'h80000000;
				1:       val = 32'h7FFFFFFF;
				2:       val = 32'h0;
				3:       val = 32'hFFFFFFFF;
				default: val = $urandom;
			endcase
			send_item(op, pos, val, 1'b0, none);
		end
		steady   = 1'b0;
		s_tvalid <= 1'b0;

		// Drain outstanding results, then give the output register time to show any stray item.
		while (pending.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);

		$display("Sent %0d list operations (%0d directed), checked %0d results; peak fill %0d.",
			items_sent, directed_items, results_seen, max_fill);
		$display("Status mix: ok %0d, underflow %0d, out of range %0d, full %0d.",
			status_hits[ST_OK], status_hits[ST_UNDERFLOW], status_hits[ST_RANGE],
			status_hits[ST_FULL]);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
